/* hdl/ror_pkg.sv */
// shared types, widths and codes for the ring of records offset lookup
package ror_pkg;

  // field widths fixed by the item format
  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 16;
  localparam int OFFSET_W = 20;
  localparam int SLOT_W   = 4;

  // default ring depth
  localparam int RING_DEPTH_DEF = 16;

  // request kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  // request payload
  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] entry_handle;
    logic [LENGTH_W-1:0] entry_length;
    logic [OFFSET_W-1:0] byte_pos;
  } ror_req_t;

  // result payload
  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] found_handle;
    logic [LENGTH_W-1:0] byte_offset;
    logic                replaced;
    logic [HANDLE_W-1:0] replaced_handle;
  } ror_rsp_t;

  // one stored record
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } ring_rec_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_FIND,
    ST_RESULT
  } ror_state_t;

endpackage

/* hdl/ror_chan_if.sv */
// valid/ready channel carrying one payload per request
interface ror_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ror_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module ror_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/ring_of_records_offset_lookup.sv */
// ring of records with overwrite of the oldest and lookup by byte offset
//
// Requests arrive on req (valid/ready), one result per request leaves on rsp.
// An add request stores {entry_handle, entry_length} at the write slot; when
// the ring is full it overwrites the oldest record and reports its handle.
// A find request walks the stored records from the oldest, subtracting each
// length from byte_pos, and reports slot, handle and offset inside the
// record that holds the byte, or found = 0.
// Records sit in one ram with a registered read.
// An add reads the old record, writes the new record and then passes on the
// result. A find walk issues one ram read per cycle, pipelined against the
// length compare, and stops early at the matching record. One request is in
// work at a time; req.ready is high while the sequencer is idle, so no new
// request is taken before the last one has left its result step.
// The result sits in an output register: the next request is accepted while
// it waits, and a stalled receiver only holds the sequencer in its result
// step once a second result is ready.
// Reset empties the ring at once (slot pointers and full flag cleared); the
// ram needs no clearing since data read from an unwritten slot is never used.
module ring_of_records_offset_lookup
  import ror_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  ror_chan_if.sink req,
  ror_chan_if.source rsp
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int RW = $bits(ring_rec_t);

  ror_state_t          state, state_next;
  logic [AW-1:0]       write_slot, write_slot_next;
  logic [AW-1:0]       read_slot, read_slot_next;
  logic                ring_full, ring_full_next;
  ror_req_t            cur, cur_next;
  logic [CW-1:0]       n_cnt, n_cnt_next;
  logic [CW-1:0]       iss_cnt, iss_cnt_next;
  logic [AW-1:0]       iss_idx, iss_idx_next;
  logic                chk_pending, chk_pending_next;
  logic [AW-1:0]       chk_idx, chk_idx_next;
  logic [OFFSET_W-1:0] target, target_next;
  ror_rsp_t            res, res_next;
  logic                out_valid, out_valid_next;
  ror_rsp_t            out_data, out_data_next;

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [RW-1:0]       ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [RW-1:0]       ram_rd_data;
  ring_rec_t           rec_rd;
  logic [CW-1:0]       ring_count;
  logic [OFFSET_W-1:0] rec_len;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] s);
    ring_next = (s == AW'(RING_DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  // record store
  ror_ram #(
    .WIDTH (RW),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rec_rd  = ring_rec_t'(ram_rd_data);
  assign rec_len = OFFSET_W'(rec_rd.length);

  // number of stored records
  always_comb begin
    if (ring_full) begin
      ring_count = CW'(RING_DEPTH);
    end else if (write_slot >= read_slot) begin
      ring_count = CW'(write_slot) - CW'(read_slot);
    end else begin
      ring_count = CW'(write_slot) + CW'(RING_DEPTH) - CW'(read_slot);
    end
  end

  // output channel
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign req.ready = (state == ST_IDLE);

  // sequencer: next state and datapath control
  always_comb begin
    state_next       = state;
    write_slot_next  = write_slot;
    read_slot_next   = read_slot;
    ring_full_next   = ring_full;
    cur_next         = cur;
    n_cnt_next       = n_cnt;
    iss_cnt_next     = iss_cnt;
    iss_idx_next     = iss_idx;
    chk_pending_next = 1'b0;
    chk_idx_next     = chk_idx;
    target_next      = target;
    res_next         = res;
    out_valid_next   = out_valid && !rsp.ready;
    out_data_next    = out_data;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = write_slot;
    ram_wr_data      = {cur.entry_handle, cur.entry_length};
    ram_rd_en        = 1'b0;
    ram_rd_addr      = iss_idx;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cur_next     = req.data;
          res_next     = '0;
          target_next  = req.data.byte_pos;
          iss_idx_next = read_slot;
          iss_cnt_next = '0;
          n_cnt_next   = ring_count;
          state_next   = (req.data.kind == KIND_ADD) ? ST_ADD_RD : ST_FIND;
        end
      end

      // fetch the record that may be overwritten
      ST_ADD_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = write_slot;
        state_next  = ST_ADD_WR;
      end

      // write the new record, move the pointers
      ST_ADD_WR: begin
        ram_wr_en = 1'b1;
        if (ring_full) begin
          res_next.replaced        = 1'b1;
          res_next.replaced_handle = rec_rd.handle;
          read_slot_next           = ring_next(read_slot);
        end
        write_slot_next = ring_next(write_slot);
        ring_full_next  = ring_full || (read_slot_next == write_slot_next);
        state_next      = ST_RESULT;
      end

      // pipelined walk: issue one read, check the previous one
      ST_FIND: begin
        if (iss_cnt < n_cnt) begin
          ram_rd_en        = 1'b1;
          ram_rd_addr      = iss_idx;
          iss_idx_next     = ring_next(iss_idx);
          iss_cnt_next     = iss_cnt + CW'(1);
          chk_pending_next = 1'b1;
          chk_idx_next     = iss_idx;
        end
        if (chk_pending) begin
          if (target >= rec_len) begin
            target_next = target - rec_len;
          end else begin
            res_next.found        = 1'b1;
            res_next.slot         = SLOT_W'(chk_idx);
            res_next.found_handle = rec_rd.handle;
            res_next.byte_offset  = target[LENGTH_W-1:0];
            state_next            = ST_RESULT;
          end
        end else if (iss_cnt == n_cnt) begin
          // walked every record without a match
          state_next = ST_RESULT;
        end
      end

      // hand the result to the output register
      ST_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_slot  <= '0;
      read_slot   <= '0;
      ring_full   <= 1'b0;
      chk_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      write_slot  <= write_slot_next;
      read_slot   <= read_slot_next;
      ring_full   <= ring_full_next;
      chk_pending <= chk_pending_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    n_cnt    <= n_cnt_next;
    iss_cnt  <= iss_cnt_next;
    iss_idx  <= iss_idx_next;
    chk_idx  <= chk_idx_next;
    target   <= target_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

endmodule
